FILE: sv/rpt_pkg.sv
// Package for the reddest pixel tracker: sizes, marker geometry, register
// indexes and the classified item that the front hands to the back.
// No dependencies.
`default_nettype none

package rpt_pkg;

    // frame limits and counter widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 24;
    localparam int CH_W       = PIXEL_BITS / 3;
    localparam int CNT_W      = 12;
    localparam int SIZE_W     = CNT_W + 1;
    localparam int SUM_W      = CH_W + 1;
    localparam int IVL_W      = 8;

    // search start and saturating frame count
    localparam int SUM_START = 255 + 255;
    localparam int COUNT_TOP = 255;

    // marker geometry, offsets from the centre
    localparam int BOX_LEFT  = 20;
    localparam int BOX_RIGHT = 19;
    localparam int BOX_EDGE  = 10;
    localparam int BOX_SIDE  = 9;
    localparam int ARM_FAR   = 29;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_INTERVAL = 2'd2
    } t_cfg_idx;

    // one classified pixel
    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic             blank;
        logic [CNT_W-1:0] mx;
        logic [CNT_W-1:0] my;
        logic             last;
    } t_cls;

endpackage

`default_nettype wire

FILE: sv/rpt_front.sv
// Front of the tracker: configuration registers, column/line counters,
// reddest pixel search, marker adoption and marker hit test.
// Depends on rpt_pkg.
`default_nettype none

module rpt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [rpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpt_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                         i_accept,
    input  logic [rpt_pkg::CH_W-1:0]     i_blue,
    input  logic [rpt_pkg::CH_W-1:0]     i_green,
    input  logic [rpt_pkg::CH_W-1:0]     i_red,
    output rpt_pkg::t_cls                o_item
);
    import rpt_pkg::*;

    localparam logic signed [SIZE_W-1:0] D_LEFT  = SIZE_W'(BOX_LEFT);
    localparam logic signed [SIZE_W-1:0] D_RIGHT = SIZE_W'(BOX_RIGHT);
    localparam logic signed [SIZE_W-1:0] D_EDGE  = SIZE_W'(BOX_EDGE);
    localparam logic signed [SIZE_W-1:0] D_SIDE  = SIZE_W'(BOX_SIDE);
    localparam logic signed [SIZE_W-1:0] D_FAR   = SIZE_W'(ARM_FAR);

    // configuration
    logic [SIZE_W-1:0] r_fw, r_fh;
    logic [IVL_W-1:0]  r_interval;

    // position and search state
    logic [CNT_W-1:0]  r_col, r_line, n_col, n_line;
    logic [CH_W-1:0]   r_best_red, n_best_red;
    logic [SUM_W-1:0]  r_best_sum, n_best_sum;
    logic [CNT_W-1:0]  r_best_col, r_best_line, n_best_col, n_best_line;
    logic [CNT_W-1:0]  r_mcol, r_mline, n_mcol, n_mline;
    logic [IVL_W-1:0]  r_fsu, n_fsu;

    logic [SIZE_W-1:0] w, h, col_inc, line_inc, my_full;
    logic              line_end, last, better;
    logic [SUM_W-1:0]  sgb;
    logic signed [SIZE_W-1:0] dx, dy;
    logic              hit_row, hit_side, hit_arm;
    logic [CH_W-1:0]   upd_red;
    logic [SUM_W-1:0]  upd_sum;
    logic [CNT_W-1:0]  upd_col, upd_line;

    // saturate the frame size into 1..max
    always_comb begin
        if (r_fw == '0) w = SIZE_W'(1);
        else if (r_fw > SIZE_W'(MAX_WIDTH)) w = SIZE_W'(MAX_WIDTH);
        else w = r_fw;
        if (r_fh == '0) h = SIZE_W'(1);
        else if (r_fh > SIZE_W'(MAX_HEIGHT)) h = SIZE_W'(MAX_HEIGHT);
        else h = r_fh;
    end

    // line and frame end
    assign col_inc  = {1'b0, r_col} + SIZE_W'(1);
    assign line_inc = {1'b0, r_line} + SIZE_W'(1);
    assign line_end = col_inc >= w;
    assign last     = line_end && (line_inc >= h);

    // marker hit test against the current centre
    assign dx = $signed({1'b0, r_col}) - $signed({1'b0, r_mcol});
    assign dy = $signed({1'b0, r_line}) - $signed({1'b0, r_mline});
    assign hit_row  = (dy == -D_EDGE || dy == D_EDGE) && dx >= -D_LEFT && dx <= D_RIGHT;
    assign hit_side = (dx == -D_LEFT || dx == D_RIGHT) && dy >= -D_SIDE && dy <= D_SIDE;
    assign hit_arm  = (dx == '0) && ((dy >= D_EDGE && dy <= D_FAR)
                                  || (dy <= -D_EDGE && dy >= -D_FAR));

    // top-based row of the marker
    assign my_full = h - {1'b0, r_mline} - SIZE_W'(1);

    // search compare, both strict
    assign sgb    = {1'b0, i_green} + {1'b0, i_blue};
    assign better = (i_red > r_best_red) && (sgb < r_best_sum);

    always_comb begin
        upd_red  = better ? i_red  : r_best_red;
        upd_sum  = better ? sgb    : r_best_sum;
        upd_col  = better ? r_col  : r_best_col;
        upd_line = better ? r_line : r_best_line;

        n_col  = line_end ? '0 : col_inc[CNT_W-1:0];
        n_line = r_line;
        if (line_end) n_line = last ? '0 : line_inc[CNT_W-1:0];

        n_best_red  = upd_red;
        n_best_sum  = upd_sum;
        n_best_col  = upd_col;
        n_best_line = upd_line;
        n_mcol      = r_mcol;
        n_mline     = r_mline;
        n_fsu       = r_fsu;
        if (last) begin
            // adopt the search or count the frame, then restart the search
            if (r_fsu >= r_interval) begin
                n_mcol  = upd_col;
                n_mline = upd_line;
                n_fsu   = '0;
            end else if (r_fsu != IVL_W'(COUNT_TOP)) begin
                n_fsu = r_fsu + IVL_W'(1);
            end
            n_best_red  = '0;
            n_best_sum  = SUM_W'(SUM_START);
            n_best_col  = '0;
            n_best_line = '0;
        end
    end

    // classified item toward the queue
    always_comb begin
        o_item.blue  = i_blue;
        o_item.green = i_green;
        o_item.red   = i_red;
        o_item.blank = hit_row || hit_side || hit_arm;
        o_item.mx    = r_mcol;
        o_item.my    = my_full[CNT_W-1:0];
        o_item.last  = last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= SIZE_W'(640);
            r_fh       <= SIZE_W'(480);
            r_interval <= IVL_W'(15);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:    r_fw       <= i_cfg_data;
                CFG_HEIGHT:   r_fh       <= i_cfg_data;
                CFG_INTERVAL: r_interval <= i_cfg_data[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_line      <= '0;
            r_best_red  <= '0;
            r_best_sum  <= SUM_W'(SUM_START);
            r_best_col  <= '0;
            r_best_line <= '0;
            r_mcol      <= '0;
            r_mline     <= '0;
            r_fsu       <= IVL_W'(COUNT_TOP);
        end else if (i_accept) begin
            r_col       <= n_col;
            r_line      <= n_line;
            r_best_red  <= n_best_red;
            r_best_sum  <= n_best_sum;
            r_best_col  <= n_best_col;
            r_best_line <= n_best_line;
            r_mcol      <= n_mcol;
            r_mline     <= n_mline;
            r_fsu       <= n_fsu;
        end
    end

    // search restarts after the last pixel of a frame
    a_search_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && last |=> r_best_sum == SUM_W'(SUM_START) && r_best_red == '0)
        else $error("search not restarted at frame end");

    // marker only moves at frame end
    a_marker_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && last) |=> $stable(r_mcol) && $stable(r_mline))
        else $error("marker moved mid-frame");

    // adoption resets the frame count
    a_adopt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && last && r_fsu >= r_interval |=> r_fsu == '0)
        else $error("frame count not cleared on adoption");

endmodule

`default_nettype wire

FILE: sv/rpt_queue.sv
// Short queue of classified pixels between front and back.
// Depends on rpt_pkg.
`default_nettype none

module rpt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  rpt_pkg::t_cls i_item,
    output logic          o_full,
    input  logic          i_rd,
    output rpt_pkg::t_cls o_item,
    output logic          o_empty
);
    import rpt_pkg::*;

    t_cls              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_item;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            if (i_rd) r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: ;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("read from empty queue");

endmodule

`default_nettype wire

FILE: sv/rpt_back.sv
// Back of the tracker: takes classified pixels from the queue, blanks the
// ones on the marker and holds the result register.
// Depends on rpt_pkg.
`default_nettype none

module rpt_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rpt_pkg::t_cls             i_item,
    input  logic                      i_q_empty,
    output logic                      o_q_rd,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [rpt_pkg::CH_W-1:0]  o_blue,
    output logic [rpt_pkg::CH_W-1:0]  o_green,
    output logic [rpt_pkg::CH_W-1:0]  o_red,
    output logic [rpt_pkg::CNT_W-1:0] o_mx,
    output logic [rpt_pkg::CNT_W-1:0] o_my,
    output logic                      o_last
);
    import rpt_pkg::*;

    logic r_valid;

    // refill the result register when it is free or being taken
    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // payload, blanked on the marker
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            o_blue  <= i_item.blank ? '0 : i_item.blue;
            o_green <= i_item.blank ? '0 : i_item.green;
            o_red   <= i_item.blank ? '0 : i_item.red;
            o_mx    <= i_item.mx;
            o_my    <= i_item.my;
            o_last  <= i_item.last;
        end
    end

endmodule

`default_nettype wire

FILE: sv/reddest_pixel_tracker_overlay_top.sv
// Top level of the reddest pixel tracker with marker overlay.
// Depends on rpt_pkg, rpt_front, rpt_queue, rpt_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  pixel in | push / full               | i_blue_in, i_green_in, i_red_in
//  result   | empty / pop               | o_blue_out .. o_red_out, o_marker_x/y,
//           |                           | o_frame_end
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while pop keeps up; an accepted pixel reaches the
// result ports after the front classifies it into the queue and back registers it.
// Synchronous active-low reset restores the default frame size and interval,
// clears counters and search, and makes the first frame adopt.
// A 4-entry queue plus the result register absorbs stalls on pop; full rises
// once all of them hold results. Config is always ready.
`default_nettype none

module reddest_pixel_tracker_overlay_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [rpt_pkg::CH_W-1:0]     i_blue_in,
    input  logic [rpt_pkg::CH_W-1:0]     i_green_in,
    input  logic [rpt_pkg::CH_W-1:0]     i_red_in,
    output logic                         empty,
    input  logic                         pop,
    output logic [rpt_pkg::CH_W-1:0]     o_blue_out,
    output logic [rpt_pkg::CH_W-1:0]     o_green_out,
    output logic [rpt_pkg::CH_W-1:0]     o_red_out,
    output logic [rpt_pkg::CNT_W-1:0]    o_marker_x,
    output logic [rpt_pkg::CNT_W-1:0]    o_marker_y,
    output logic                         o_frame_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpt_pkg::SIZE_W-1:0]   i_cfg_data
);
    import rpt_pkg::*;

    t_cls front_item, q_item;
    logic accept, q_full, q_empty, q_rd;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    rpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_blue      (i_blue_in),
        .i_green     (i_green_in),
        .i_red       (i_red_in),
        .o_item      (front_item)
    );

    rpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    rpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (q_item),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_blue    (o_blue_out),
        .o_green   (o_green_out),
        .o_red     (o_red_out),
        .o_mx      (o_marker_x),
        .o_my      (o_marker_y),
        .o_last    (o_frame_end)
    );

endmodule

`default_nettype wire
